### design/sfd_pkg.sv
// Shared constants and types of the sensor frame deframer.
`default_nettype none
package sfd_pkg;

  localparam int MAX_DATA = 32;                    // largest payload per frame
  localparam int PAY_AW   = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int MEM_AW   = PAY_AW + 1;            // bank bit on top
  localparam int CNT_W    = 6;                     // data_count width

  localparam logic [7:0]  FRAME_HEAD   = 8'h55;
  localparam logic [7:0]  RESET_CMD    = 8'h01;
  localparam logic [15:0] RESET_NET_ID = 16'h0016;

  // register index, taken from paddr[2]
  localparam logic REG_NET_ID = 1'b0;
  localparam logic REG_CMD    = 1'b1;

  // accepted frame, handed from parser to emitter
  typedef struct packed {
    logic [7:0]       src;
    logic [7:0]       ack;
    logic [CNT_W-1:0] cnt;
    logic             bank;
  } frame_desc_t;

  // payload buffer write port
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } pay_wr_t;

  // back-pressure seen by the parser
  typedef struct packed {
    logic q_full;
    logic banks_full;
  } front_hold_t;

  typedef enum logic [8:0] {
    PH_SEEK = 9'b000000001,
    PH_CMD  = 9'b000000010,
    PH_NETH = 9'b000000100,
    PH_NETL = 9'b000001000,
    PH_ADDR = 9'b000010000,
    PH_ACK  = 9'b000100000,
    PH_LEN  = 9'b001000000,
    PH_DATA = 9'b010000000,
    PH_SUM  = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_HDR  = 3'b010,
    BK_DATA = 3'b100
  } back_state_t;

endpackage : sfd_pkg
`default_nettype wire

### design/sensor_frame_deframer.sv
// Top level of the sensor frame deframer: APB registers, parser, queue, emitter.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall   | rx_byte, packet_end
//  out     | output    | out_valid / out_stall | is_header, source_addr, ack_code,
//          |           |                       | data_count, data_byte, last
//  cfg     | input     | APB psel/penable      | paddr 0: own_net_id, paddr 4: accepted_cmd
//
// The parser takes one byte per cycle unless it stalls. Results are registered:
// the checksum byte pushes a descriptor that the idle emitter pops; a frame of N
// data bytes gives a header item and N data items, and the emitter passes through
// idle before the next frame starts. Payload sits in two banks; the parser stalls
// on a data byte while both banks are claimed (queued or draining), and on a
// checksum byte while the two-entry queue is full. Output stalls hold the emitter and reach the parser only that way.
// Reset is synchronous and needs no clearing pass; no data item carries a buffer byte
// that was not written.
`default_nettype none
module sensor_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        packet_end,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_header,
  output logic [7:0]       source_addr,
  output logic [7:0]       ack_code,
  output logic [5:0]       data_count,
  output logic [7:0]       data_byte,
  output logic             last,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sfd_pkg::*;

  logic [15:0] own_net_id;
  logic [7:0]  accepted_cmd;
  logic        cfg_wr;

  front_hold_t hold;
  pay_wr_t     pay_wr;
  logic        push;
  frame_desc_t push_desc;
  logic        pop;
  logic        q_valid;
  frame_desc_t head;
  logic [1:0]  q_count;
  logic        busy;

  // registers: always ready, word decode on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_net_id   <= RESET_NET_ID;
      accepted_cmd <= RESET_CMD;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NET_ID: own_net_id   <= pwdata[15:0];
        REG_CMD:    accepted_cmd <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NET_ID: prdata = {16'd0, own_net_id};
      REG_CMD:    prdata = {24'd0, accepted_cmd};
      default:    prdata = '0;
    endcase
  end

  // banks claimed = queued frames plus the one being drained
  assign hold.q_full     = (q_count == 2'd2);
  assign hold.banks_full = ({1'b0, q_count} + {2'd0, busy}) >= 3'd2;

  sfd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .packet_end   (packet_end),
    .own_net_id   (own_net_id),
    .accepted_cmd (accepted_cmd),
    .hold         (hold),
    .pay_wr       (pay_wr),
    .push         (push),
    .push_desc    (push_desc)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head),
    .count     (q_count)
  );

  sfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pay_wr      (pay_wr),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_header   (is_header),
    .source_addr (source_addr),
    .ack_code    (ack_code),
    .data_count  (data_count),
    .data_byte   (data_byte),
    .last        (last)
  );

endmodule : sensor_frame_deframer
`default_nettype wire

### design/sfd_front.sv
// Byte parser: header hunt, field capture, checksum, payload writes.
`default_nettype none
module sfd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                packet_end,
  input  wire logic [15:0]         own_net_id,
  input  wire logic [7:0]          accepted_cmd,
  input  wire sfd_pkg::front_hold_t hold,
  output sfd_pkg::pay_wr_t         pay_wr,
  output logic                     push,
  output sfd_pkg::frame_desc_t     push_desc
);
  import sfd_pkg::*;

  phase_t           phase, phase_next;
  logic [7:0]       sum_acc, sum_acc_next;
  logic [7:0]       net_high, net_high_next;
  logic [7:0]       net_low, net_low_next;
  logic [7:0]       src_addr, src_addr_next;
  logic [7:0]       ack_byte, ack_byte_next;
  logic [7:0]       len_byte, len_byte_next;
  logic [CNT_W-1:0] data_index, data_index_next;
  logic             discard_rest, discard_rest_next;
  logic             wr_bank, wr_bank_next;

  logic             in_fire;
  logic [7:0]       sum_add;
  logic [7:0]       len_m1;
  logic [7:0]       rx_m1;
  logic [CNT_W-1:0] idx_inc;

  assign in_stall = ~discard_rest &
                    (((phase == PH_DATA) & hold.banks_full) |
                     ((phase == PH_SUM) & hold.q_full));
  assign in_fire  = in_valid & ~in_stall;
  assign sum_add  = sum_acc + rx_byte;
  assign len_m1   = len_byte - 8'd1;
  assign rx_m1    = rx_byte - 8'd1;
  assign idx_inc  = data_index + CNT_W'(1);

  always_comb begin
    phase_next        = phase;
    sum_acc_next      = sum_acc;
    net_high_next     = net_high;
    net_low_next      = net_low;
    src_addr_next     = src_addr;
    ack_byte_next     = ack_byte;
    len_byte_next     = len_byte;
    data_index_next   = data_index;
    discard_rest_next = discard_rest;
    wr_bank_next      = wr_bank;
    pay_wr.we         = 1'b0;
    pay_wr.addr       = {wr_bank, data_index[PAY_AW-1:0]};
    pay_wr.data       = rx_byte;
    push              = 1'b0;
    push_desc.src     = src_addr;
    push_desc.ack     = ack_byte;
    push_desc.cnt     = len_m1[CNT_W-1:0];
    push_desc.bank    = wr_bank;

    if (in_fire) begin
      if (!discard_rest) begin
        unique case (phase)
          PH_SEEK: begin
            if (rx_byte == FRAME_HEAD) begin
              sum_acc_next = rx_byte;
              phase_next   = PH_CMD;
            end
          end
          PH_CMD: begin
            if (rx_byte != accepted_cmd) begin
              discard_rest_next = 1'b1;
            end else begin
              sum_acc_next = sum_add;
              phase_next   = PH_NETH;
            end
          end
          PH_NETH: begin
            net_high_next = rx_byte;
            sum_acc_next  = sum_add;
            phase_next    = PH_NETL;
          end
          PH_NETL: begin
            net_low_next = rx_byte;
            sum_acc_next = sum_add;
            phase_next   = PH_ADDR;
          end
          PH_ADDR: begin
            src_addr_next = rx_byte;
            sum_acc_next  = sum_add;
            phase_next    = PH_ACK;
          end
          PH_ACK: begin
            ack_byte_next = rx_byte;
            sum_acc_next  = sum_add;
            phase_next    = PH_LEN;
          end
          PH_LEN: begin
            len_byte_next   = rx_byte;
            sum_acc_next    = sum_add;
            data_index_next = '0;
            if (rx_byte == 8'd0 || rx_m1 > 8'(MAX_DATA)) begin
              discard_rest_next = 1'b1;
            end else begin
              phase_next = (rx_byte == 8'd1) ? PH_SUM : PH_DATA;
            end
          end
          PH_DATA: begin
            pay_wr.we       = 1'b1;
            data_index_next = idx_inc;
            sum_acc_next    = sum_add;
            if ({{(8-CNT_W){1'b0}}, idx_inc} >= len_m1) begin
              phase_next = PH_SUM;
            end
          end
          PH_SUM: begin
            if (rx_byte == sum_acc && {net_high, net_low} == own_net_id) begin
              push         = 1'b1;
              wr_bank_next = ~wr_bank;
            end
            discard_rest_next = 1'b1;
          end
          default: begin
            discard_rest_next = 1'b1;
          end
        endcase
      end
      if (packet_end) begin
        phase_next        = PH_SEEK;
        sum_acc_next      = '0;
        data_index_next   = '0;
        discard_rest_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEEK;
      sum_acc      <= '0;
      net_high     <= '0;
      net_low      <= '0;
      src_addr     <= '0;
      ack_byte     <= '0;
      len_byte     <= '0;
      data_index   <= '0;
      discard_rest <= 1'b0;
      wr_bank      <= 1'b0;
    end else begin
      phase        <= phase_next;
      sum_acc      <= sum_acc_next;
      net_high     <= net_high_next;
      net_low      <= net_low_next;
      src_addr     <= src_addr_next;
      ack_byte     <= ack_byte_next;
      len_byte     <= len_byte_next;
      data_index   <= data_index_next;
      discard_rest <= discard_rest_next;
      wr_bank      <= wr_bank_next;
    end
  end

endmodule : sfd_front
`default_nettype wire

### design/sfd_queue.sv
// Two-entry queue of accepted frame descriptors.
`default_nettype none
module sfd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sfd_pkg::frame_desc_t push_desc,
  input  wire logic                 pop,
  output logic                      q_valid,
  output sfd_pkg::frame_desc_t      head,
  output logic [1:0]                count
);
  import sfd_pkg::*;

  frame_desc_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;

  assign q_valid = (count != 2'd0);
  assign head    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule : sfd_queue
`default_nettype wire

### design/sfd_back.sv
// Result emitter: header item then payload bytes read from the two-bank buffer.
`default_nettype none
module sfd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sfd_pkg::pay_wr_t     pay_wr,
  input  wire logic                 q_valid,
  input  wire sfd_pkg::frame_desc_t head,
  output logic                      pop,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      is_header,
  output logic [7:0]                source_addr,
  output logic [7:0]                ack_code,
  output logic [5:0]                data_count,
  output logic [7:0]                data_byte,
  output logic                      last
);
  import sfd_pkg::*;

  logic [7:0] payload [2**MEM_AW];
  logic [7:0] rd_data;

  back_state_t      state, state_next;
  frame_desc_t      cur, cur_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] idx_inc;
  logic             out_fire;
  logic [MEM_AW-1:0] rd_addr;

  assign idx_inc  = idx + CNT_W'(1);
  assign out_fire = out_valid & ~out_stall;
  assign busy     = (state != BK_IDLE);

  assign out_valid   = (state == BK_HDR) | (state == BK_DATA);
  assign is_header   = (state == BK_HDR);
  assign source_addr = cur.src;
  assign ack_code    = cur.ack;
  assign data_count  = cur.cnt;
  assign data_byte   = (state == BK_HDR) ? 8'd0 : rd_data;
  assign last        = (state == BK_HDR) ? (cur.cnt == '0) : (idx_inc == cur.cnt);

  // look one byte ahead so the registered read is ready when the item moves
  always_comb begin
    rd_addr    = {cur.bank, idx[PAY_AW-1:0]};
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        rd_addr = {head.bank, {PAY_AW{1'b0}}};
        if (q_valid) begin
          pop        = 1'b1;
          cur_next   = head;
          idx_next   = '0;
          state_next = BK_HDR;
        end
      end
      BK_HDR: begin
        if (out_fire) begin
          state_next = (cur.cnt == '0) ? BK_IDLE : BK_DATA;
        end
      end
      BK_DATA: begin
        if (out_fire) begin
          rd_addr  = {cur.bank, idx_inc[PAY_AW-1:0]};
          idx_next = idx_inc;
          if (idx_inc == cur.cnt) state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pay_wr.we) begin
      payload[pay_wr.addr] <= pay_wr.data;
    end
    rd_data <= payload[rd_addr];
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : sfd_back
`default_nettype wire

### tb/sfd_checker.sv
// Checker of the sensor frame deframer: mirrors registers, predicts result items, compares.
module sfd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        packet_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        is_header,
  input  logic [7:0]  source_addr,
  input  logic [7:0]  ack_code,
  input  logic [5:0]  data_count,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          results_due,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  typedef struct packed {
    logic       hdr;
    logic [7:0] src;
    logic [7:0] ack;
    logic [5:0] cnt;
    logic [7:0] dat;
    logic       lst;
  } frame_item_t;

  // register copies
  logic [15:0] net_id_cfg;
  logic [7:0]  cmd_cfg;

  // parser copy
  phase_t      ph;
  logic [7:0]  sum_q, net_hi, net_lo, src_q, ack_q, len_q;
  logic [5:0]  idx;
  logic [7:0]  pay [MAX_DATA];
  logic        skip_rest;

  frame_item_t frame_items_due[$];
  frame_item_t want;

  task automatic queue_item(input logic hdr, input logic [5:0] cnt, input logic [7:0] dat,
                            input logic lst);
    frame_item_t it;
    it = '{hdr: hdr, src: src_q, ack: ack_q, cnt: cnt, dat: dat, lst: lst};
    frame_items_due.push_back(it);
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic pe);
    int cnt;
    if (!skip_rest) begin
      case (ph)
        PH_SEEK: if (b == FRAME_HEAD) begin
          sum_q = b;
          ph = PH_CMD;
        end
        PH_CMD: if (b != cmd_cfg) begin
          skip_rest = 1'b1;
        end else begin
          sum_q += b;
          ph = PH_NETH;
        end
        PH_NETH: begin
          net_hi = b;
          sum_q += b;
          ph = PH_NETL;
        end
        PH_NETL: begin
          net_lo = b;
          sum_q += b;
          ph = PH_ADDR;
        end
        PH_ADDR: begin
          src_q = b;
          sum_q += b;
          ph = PH_ACK;
        end
        PH_ACK: begin
          ack_q = b;
          sum_q += b;
          ph = PH_LEN;
        end
        PH_LEN: begin
          len_q = b;
          sum_q += b;
          idx = '0;
          if (b == 8'd0 || int'(b) > MAX_DATA + 1) skip_rest = 1'b1;
          else ph = (b == 8'd1) ? PH_SUM : PH_DATA;
        end
        PH_DATA: begin
          if (int'(idx) < MAX_DATA) pay[idx[PAY_AW-1:0]] = b;
          idx = idx + 6'd1;
          sum_q += b;
          if (int'(idx) >= int'(len_q) - 1) ph = PH_SUM;
        end
        PH_SUM: begin
          if (b == sum_q && {net_hi, net_lo} == net_id_cfg) begin
            cnt = int'(len_q) - 1;
            if (cnt > MAX_DATA) cnt = MAX_DATA;
            queue_item(1'b1, cnt[5:0], 8'h00, cnt == 0);
            for (int i = 0; i < cnt; i++) queue_item(1'b0, cnt[5:0], pay[i], i + 1 == cnt);
          end
          skip_rest = 1'b1;
        end
        default: skip_rest = 1'b1;
      endcase
    end
    if (pe) begin
      ph = PH_SEEK;
      sum_q = '0;
      idx = '0;
      skip_rest = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      net_id_cfg = RESET_NET_ID;
      cmd_cfg = RESET_CMD;
      ph = PH_SEEK;
      sum_q = '0;
      net_hi = '0;
      net_lo = '0;
      src_q = '0;
      ack_q = '0;
      len_q = '0;
      idx = '0;
      skip_rest = 1'b0;
      frame_items_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_NET_ID) net_id_cfg = pwdata[15:0];
        else if (paddr[2] == REG_CMD) cmd_cfg = pwdata[7:0];
      end
      if (in_valid && !in_stall) deframe_byte(rx_byte, packet_end);
      if (out_valid && !out_stall) begin
        if (frame_items_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hdr=%0b src=%0h ack=%0h",
                   $time, is_header, source_addr, ack_code);
          mismatches++;
        end else begin
          want = frame_items_due.pop_front();
          check_field("is_header", 8'(want.hdr), 8'(is_header));
          check_field("source_addr", want.src, source_addr);
          check_field("ack_code", want.ack, ack_code);
          check_field("data_count", 8'(want.cnt), 8'(data_count));
          check_field("data_byte", want.dat, data_byte);
          check_field("last", 8'(want.lst), 8'(last));
          results_checked++;
        end
      end
    end
    results_due <= frame_items_due.size();
  end

endmodule

### tb/sensor_frame_deframer_tb.sv
// Testbench top of the sensor frame deframer: packet stimulus, stalls and verdict.
module sensor_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  // packet flavors the generator can build
  typedef enum int {
    PK_GOOD,
    PK_BAD_CMD,
    PK_BAD_NET,
    PK_BAD_SUM,
    PK_ZERO_LEN,
    PK_OVERSIZE,
    PK_TRUNC,
    PK_NO_HEAD
  } pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        packet_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_header;
  logic [7:0]  source_addr;
  logic [7:0]  ack_code;
  logic [5:0]  data_count;
  logic [7:0]  data_byte;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches, results_due, results_checked;

  // quiet: no idling on either side (last part of the run)
  bit          quiet = 1'b0;
  // current register values, used to build frames that pass or fail on purpose
  logic [15:0] net_id_now = RESET_NET_ID;
  logic [7:0]  cmd_now = RESET_CMD;
  logic [7:0]  packet_bytes[$];
  int          bytes_sent = 0;
  int          frame_bytes = 0;   // header..checksum bytes only, noise excluded
  int          packets_sent = 0;
  int          settings_run = 0;

  always #2 clk = ~clk;

  sensor_frame_deframer uut (
    .clk, .rst,
    .in_valid, .in_stall, .rx_byte, .packet_end,
    .out_valid, .out_stall, .is_header, .source_addr, .ack_code, .data_count,
    .data_byte, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sfd_checker frame_check (
    .clk, .rst,
    .in_valid, .in_stall, .rx_byte, .packet_end,
    .out_valid, .out_stall, .is_header, .source_addr, .ack_code, .data_count,
    .data_byte, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .results_due, .results_checked
  );

  // Hard stop. A correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Output back-pressure: free runs then stall bursts.
  // Every NBA is separated from the next by a clock edge.
  initial begin
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if (!quiet) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end
  end

  // One item on the byte channel. Returns at the edge that takes it; the caller
  // either drives the next item or lowers valid in that same step, never both.
  task automatic send_byte(input logic [7:0] b, input logic pe);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    packet_end <= pe;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Sends the assembled packet, packet_end on its last byte.
  task automatic send_packet();
    for (int i = 0; i < packet_bytes.size(); i++)
      send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
    packet_bytes.delete();
    packets_sent++;
  endtask

  // Filler bytes; without head_ok they never hold the header value, so the
  // search does not start inside them.
  task automatic add_noise(input int n, input bit head_ok);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (!head_ok && b == FRAME_HEAD) b = 8'h54;
      packet_bytes.push_back(b);
    end
  endtask

  // Appends one frame. fill < 0 gives random payload, else a constant byte.
  // Oversize lengths carry at most 2 payload bytes since they are ignored anyway.
  task automatic add_frame(input pkt_kind_t kind, input int len, input logic [7:0] src,
                           input logic [7:0] ack, input int fill);
    logic [7:0]  hdr [7];
    logic [15:0] net;
    logic [7:0]  sum, b;
    int          ndata, start;
    start = packet_bytes.size();
    net = net_id_now;
    if (kind == PK_BAD_NET) net = net ^ (16'd1 << $urandom_range(0, 15));
    hdr[0] = FRAME_HEAD;
    hdr[1] = cmd_now;
    if (kind == PK_BAD_CMD) hdr[1] = cmd_now ^ (8'd1 << $urandom_range(0, 7));
    hdr[2] = net[15:8];
    hdr[3] = net[7:0];
    hdr[4] = src;
    hdr[5] = ack;
    hdr[6] = len[7:0];
    sum = 8'h00;
    foreach (hdr[i]) begin
      packet_bytes.push_back(hdr[i]);
      sum += hdr[i];
    end
    ndata = (len == 0) ? 0 : ((len - 1 > MAX_DATA) ? 2 : len - 1);
    for (int i = 0; i < ndata; i++) begin
      b = 8'($urandom);
      if (fill >= 0) b = fill[7:0];
      packet_bytes.push_back(b);
      sum += b;
    end
    if (kind == PK_BAD_SUM) sum ^= 8'd1 << $urandom_range(0, 7);
    packet_bytes.push_back(sum);
    // truncated: cut at least the checksum, keep at least the header byte
    if (kind == PK_TRUNC)
      repeat ($urandom_range(1, packet_bytes.size() - start - 1)) void'(packet_bytes.pop_back());
    frame_bytes += packet_bytes.size() - start;
  endtask

  // Mostly good frames with short payloads; the rest hits every drop path.
  task automatic random_packet();
    int        r, len;
    pkt_kind_t kind;
    r = $urandom_range(0, 99);
    kind = (r < 62) ? PK_GOOD : (r < 67) ? PK_BAD_CMD : (r < 72) ? PK_BAD_NET :
           (r < 78) ? PK_BAD_SUM : (r < 81) ? PK_ZERO_LEN : (r < 85) ? PK_OVERSIZE :
           (r < 94) ? PK_TRUNC : PK_NO_HEAD;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 33) : $urandom_range(1, 9);
    if (kind == PK_ZERO_LEN) len = 0;
    else if (kind == PK_OVERSIZE) len = $urandom_range(34, 255);
    if (kind == PK_NO_HEAD) begin
      add_noise($urandom_range(1, 12), 1'b0);
    end else begin
      if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 4), 1'b0);
      add_frame(kind, len, 8'($urandom), 8'($urandom), -1);
      // bytes after the frame must be ignored, header value included
      if (kind != PK_TRUNC && $urandom_range(0, 2) == 0) add_noise($urandom_range(1, 6), 1'b1);
    end
    send_packet();
  endtask

  task automatic random_phase(input int target);
    int start;
    start = frame_bytes;
    while (frame_bytes - start < target) random_packet();
  endtask

  // Sender holds off until every expected item is out, and idles on past that so a
  // dropped frame in flight has settled before registers change.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup, access, then an idle phase with psel low so psel never toggles twice
  // in a step between back-to-back writes.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Upper pwdata bits are junk on purpose: only the register width counts.
  task automatic apply_setting(input logic [15:0] net, input logic [7:0] cmd);
    logic [31:0] junk;
    wait_drained();
    junk = $urandom;
    write_reg(REG_NET_ID, {junk[31:16], net});
    junk = $urandom;
    write_reg(REG_CMD, {junk[31:8], cmd});
    net_id_now = net;
    cmd_now = cmd;
    settings_run++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apply_setting(RESET_NET_ID, RESET_CMD);

    // --- directed part ---
    // header only: zero data bytes, header item carries last
    add_frame(PK_GOOD, 1, 8'h00, 8'h00, -1);
    send_packet();
    // field extremes
    add_frame(PK_GOOD, 3, 8'hFF, 8'hFF, 8'h00);
    send_packet();
    add_frame(PK_GOOD, 2, 8'h01, 8'h02, 8'hFF);
    send_packet();
    // leading noise, then trailing bytes with a stray header
    add_noise(3, 1'b0);
    add_frame(PK_GOOD, 2, 8'($urandom), 8'h01, -1);
    add_noise(4, 1'b1);
    packet_bytes.push_back(FRAME_HEAD);
    send_packet();
    // command mismatch; a valid frame later in the same packet stays ignored
    add_frame(PK_BAD_CMD, 2, 8'($urandom), 8'($urandom), -1);
    add_frame(PK_GOOD, 2, 8'($urandom), 8'($urandom), -1);
    send_packet();
    // zero length, oversize just past the limit and at the field maximum
    add_frame(PK_ZERO_LEN, 0, 8'($urandom), 8'($urandom), -1);
    send_packet();
    add_frame(PK_OVERSIZE, MAX_DATA + 2, 8'($urandom), 8'($urandom), -1);
    send_packet();
    add_frame(PK_OVERSIZE, 255, 8'($urandom), 8'($urandom), -1);
    send_packet();
    // checksum mismatch, net id mismatch
    add_frame(PK_BAD_SUM, 4, 8'($urandom), 8'($urandom), -1);
    send_packet();
    add_frame(PK_BAD_NET, 4, 8'($urandom), 8'($urandom), -1);
    send_packet();
    // truncated frame, then a good one in the next packet
    add_frame(PK_TRUNC, 6, 8'($urandom), 8'($urandom), -1);
    send_packet();
    add_frame(PK_GOOD, 3, 8'($urandom), 8'($urandom), -1);
    send_packet();
    // no header at all, and a packet that is only a header byte
    add_noise(6, 1'b0);
    send_packet();
    packet_bytes.push_back(FRAME_HEAD);
    send_packet();
    // largest payload
    add_frame(PK_GOOD, MAX_DATA + 1, 8'($urandom), 8'($urandom), -1);
    send_packet();

    // --- random part, several register settings ---
    apply_setting(16'hFFFF, 8'hFF);
    random_phase(15);
    apply_setting(16'h0000, 8'h00);
    random_phase(15);
    apply_setting(16'($urandom), 8'($urandom));
    random_phase(15);
    // last stretch runs at full rate on both sides
    quiet = 1'b1;
    apply_setting(16'($urandom), 8'($urandom));
    random_phase(15);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Run covered %0d packets, %0d input bytes, %0d register settings.",
             packets_sent, bytes_sent, settings_run);
    $display("Result items checked: %0d, mismatches: %0d.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
